// ----- hw/rtl/ulas_pkg.sv -----
// ulas_pkg: shared types, byte constants and letter table for the accent stripper
// no dependencies
package ulas_pkg;

	localparam logic [7:0] BYTE_ASCII_LIMIT = 8'h80;
	localparam logic [7:0] BYTE_LEAD_C3     = 8'hC3;
	localparam logic [1:0] MARK_CONT        = 2'b10;
	localparam logic [2:0] MARK_LEAD2       = 3'b110;
	localparam logic [3:0] MARK_LEAD3       = 4'b1110;
	localparam logic [4:0] MARK_LEAD4       = 5'b11110;
	localparam logic [1:0] SKIP_LEAD3       = 2'd2;
	localparam logic [1:0] SKIP_LEAD4       = 2'd3;

	typedef struct packed {
		logic       pending;
		logic       is_c3;
		logic [1:0] skip;
	} dec_state_t;

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic       valid0;
		logic       last0;
		logic [7:0] byte1;
		logic       last1;
	} dec_result_t;

	// plain letter for code point 0xc0 + idx, zero when unknown
	function automatic logic [7:0] letter(input logic [5:0] idx);
		logic [7:0] l;
		case (idx)
			6'h00, 6'h01, 6'h02, 6'h03, 6'h04: l = 8'h41;
			6'h07: l = 8'h43;
			6'h08, 6'h09, 6'h0A, 6'h0B: l = 8'h45;
			6'h0C, 6'h0D, 6'h0E, 6'h0F: l = 8'h49;
			6'h11: l = 8'h4E;
			6'h12, 6'h13, 6'h14, 6'h15, 6'h16: l = 8'h4F;
			6'h19, 6'h1A, 6'h1B, 6'h1C: l = 8'h55;
			6'h1D: l = 8'h59;
			6'h20, 6'h21, 6'h22, 6'h23, 6'h24: l = 8'h61;
			6'h27: l = 8'h63;
			6'h28, 6'h29, 6'h2A, 6'h2B: l = 8'h65;
			6'h2C, 6'h2D, 6'h2E, 6'h2F: l = 8'h69;
			6'h31: l = 8'h6E;
			6'h32, 6'h33, 6'h34, 6'h35, 6'h36: l = 8'h6F;
			6'h39, 6'h3A, 6'h3B, 6'h3C: l = 8'h75;
			6'h3D, 6'h3F: l = 8'h79;
			default: l = 8'h00;
		endcase
		return l;
	endfunction

endpackage

// ----- hw/rtl/ulas_decode.sv -----
// ulas_decode: combinational decode of one byte against the sequence state
// depends on ulas_pkg
module ulas_decode (
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  ulas_pkg::dec_state_t cur,
	output ulas_pkg::dec_state_t nxt,
	output ulas_pkg::dec_result_t res
);

	logic [7:0] lt;

	always_comb begin
		lt = 8'h00;
		nxt = cur;
		res = '0;
		res.valid0 = 1'b1;
		if (cur.skip != 2'd0) begin
			nxt.skip = cur.skip - 2'd1;
		end else if (cur.pending) begin
			nxt.pending = 1'b0;
			nxt.is_c3 = 1'b0;
			if (cur.is_c3) begin
				if (in_byte[7:6] == ulas_pkg::MARK_CONT)
					lt = ulas_pkg::letter(in_byte[5:0]);
				if (lt != 8'h00) begin
					res.count = 2'd1;
					res.byte0 = lt;
				end else begin
					res.count = 2'd2;
					res.byte0 = ulas_pkg::BYTE_LEAD_C3;
					res.byte1 = in_byte;
				end
			end
		end else if (in_byte < ulas_pkg::BYTE_ASCII_LIMIT) begin
			res.count = 2'd1;
			res.byte0 = in_byte;
		end else if (in_byte[7:5] == ulas_pkg::MARK_LEAD2) begin
			if (!in_last) begin
				nxt.pending = 1'b1;
				nxt.is_c3 = (in_byte == ulas_pkg::BYTE_LEAD_C3);
			end
		end else if (in_byte[7:4] == ulas_pkg::MARK_LEAD3) begin
			nxt.skip = ulas_pkg::SKIP_LEAD3;
		end else if (in_byte[7:3] == ulas_pkg::MARK_LEAD4) begin
			nxt.skip = ulas_pkg::SKIP_LEAD4;
		end
		if (in_last) begin
			nxt = '0;
			case (res.count)
				2'd0: begin
					res.count = 2'd1;
					res.byte0 = 8'h00;
					res.valid0 = 1'b0;
					res.last0 = 1'b1;
				end
				2'd1: res.last0 = 1'b1;
				default: res.last1 = 1'b1;
			endcase
		end
	end

endmodule

// ----- hw/rtl/utf8_latin_accent_stripper.sv -----
// utf8_latin_accent_stripper: input register, decode, result register with
// one spare slot for the second byte of an unknown accented pair
// depends on ulas_pkg and ulas_decode
// a word waits in the input register until it is decoded into the result register
// throughput: one word per cycle without backpressure; two-result words stall input
// reset: clears the sequence state and the handshake valid flags, no word is pending
module utf8_latin_accent_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	ulas_pkg::dec_state_t  state_q;
	ulas_pkg::dec_state_t  state_nxt;
	ulas_pkg::dec_result_t dec;
	logic                  res_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_valid_q;
	logic                  out_last_q;
	logic                  spare_valid_q;
	logic [7:0]            spare_byte_q;
	logic                  spare_last_q;
	logic                  out_free;
	logic                  consume;

	ulas_decode u_decode (
		.in_byte (byte_s1),
		.in_last (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (dec)
	);

	assign out_free = !res_valid_q || res_ready;
	assign consume  = valid_s1 && out_free && !spare_valid_q;
	assign in_ready = !valid_s1 || consume;

	assign res_valid = res_valid_q;
	assign out_byte  = out_byte_q;
	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= '0;
			res_valid_q <= 1'b0;
			spare_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (consume) begin
				state_q <= state_nxt;
			end
			if (out_free) begin
				if (spare_valid_q) begin
					res_valid_q <= 1'b1;
					spare_valid_q <= 1'b0;
				end else if (consume) begin
					res_valid_q <= (dec.count != 2'd0);
					spare_valid_q <= (dec.count == 2'd2);
				end else begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (out_free) begin
			if (spare_valid_q) begin
				out_byte_q <= spare_byte_q;
				out_valid_q <= 1'b1;
				out_last_q <= spare_last_q;
			end else if (consume) begin
				out_byte_q <= dec.byte0;
				out_valid_q <= dec.valid0;
				out_last_q <= dec.last0;
				spare_byte_q <= dec.byte1;
				spare_last_q <= dec.last1;
			end
		end
	end

endmodule

// ----- dv/tb_utf8_latin_accent_stripper.sv -----
// tb_utf8_latin_accent_stripper: self-checking bench for the utf-8 accent stripper,
// with its own byte-level predictor, directed and random texts, idling and backpressure
// depends on ulas_pkg and the utf8_latin_accent_stripper rtl
`timescale 1ns / 1ps

module tb_utf8_latin_accent_stripper;

	localparam int HOLD_CYCLES = 64;

	typedef struct {
		logic [7:0] ch;
		logic       valid;
		logic       last;
	} out_char_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       res_valid;
	logic       res_ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;

	out_char_t  stripped_q[$];
	logic       seq_pending;
	logic       seq_c3;
	logic [1:0] seq_skip;
	int         words_in;
	int         chars_checked;
	int         texts_ended;
	int         letters_mapped;
	int         errors;
	bit         no_idle;
	bit         hold_req;

	utf8_latin_accent_stripper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_utf8_latin_accent_stripper: done, errors");
		$finish;
	end

	// plain letter for code point 0xc0 + cp, zero when no mapping
	function automatic logic [7:0] plain_letter(input logic [5:0] cp);
		logic [4:0] lo;
		logic [7:0] upper;
		lo = cp[4:0];
		if (lo <= 5'd4) upper = "A";
		else if (lo == 5'd7) upper = "C";
		else if (lo >= 5'd8 && lo <= 5'd11) upper = "E";
		else if (lo >= 5'd12 && lo <= 5'd15) upper = "I";
		else if (lo == 5'd17) upper = "N";
		else if (lo >= 5'd18 && lo <= 5'd22) upper = "O";
		else if (lo >= 5'd25 && lo <= 5'd28) upper = "U";
		else if (lo == 5'd29 || (lo == 5'd31 && cp[5])) upper = "Y";
		else upper = 8'h00;
		if (upper == 8'h00) return 8'h00;
		return cp[5] ? (upper | 8'h20) : upper;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic strip_word(input logic [7:0] ch, input logic last);
		out_char_t  emit[$];
		out_char_t  c;
		logic [7:0] l;
		if (seq_skip != 2'd0) begin
			seq_skip = seq_skip - 2'd1;
		end else if (seq_pending) begin
			seq_pending = 1'b0;
			if (seq_c3) begin
				l = (ch[7:6] == ulas_pkg::MARK_CONT) ? plain_letter(ch[5:0]) : 8'h00;
				if (l != 8'h00) begin
					emit.push_back('{l, 1'b1, 1'b0});
					letters_mapped++;
				end else begin
					emit.push_back('{ulas_pkg::BYTE_LEAD_C3, 1'b1, 1'b0});
					emit.push_back('{ch, 1'b1, 1'b0});
				end
			end
			seq_c3 = 1'b0;
		end else if (ch < ulas_pkg::BYTE_ASCII_LIMIT) begin
			emit.push_back('{ch, 1'b1, 1'b0});
		end else if (ch[7:5] == ulas_pkg::MARK_LEAD2) begin
			if (!last) begin
				seq_pending = 1'b1;
				seq_c3 = (ch == ulas_pkg::BYTE_LEAD_C3);
			end
		end else if (ch[7:4] == ulas_pkg::MARK_LEAD3) begin
			seq_skip = ulas_pkg::SKIP_LEAD3;
		end else if (ch[7:3] == ulas_pkg::MARK_LEAD4) begin
			seq_skip = ulas_pkg::SKIP_LEAD4;
		end
		if (last) begin
			if (emit.size() == 0) emit.push_back('{8'h00, 1'b0, 1'b1});
			else emit[emit.size() - 1].last = 1'b1;
			seq_pending = 1'b0;
			seq_c3 = 1'b0;
			seq_skip = 2'd0;
		end
		foreach (emit[i]) begin
			c = emit[i];
			stripped_q.push_back(c);
		end
	endtask

	always @(posedge clk) begin : monitor
		out_char_t want;
		if (arst_n && in_valid && in_ready) begin
			strip_word(in_byte, in_last);
			words_in++;
		end
		if (arst_n && res_valid && res_ready) begin
			chars_checked++;
			if (out_last) texts_ended++;
			if (stripped_q.size() == 0) begin
				$error("unexpected word: out_byte %02h out_valid %0b out_last %0b",
					out_byte, out_valid, out_last);
				errors++;
			end else begin
				want = stripped_q.pop_front();
				if (out_valid !== want.valid) begin
					$error("out_valid: expected %0b, got %0b", want.valid, out_valid);
					errors++;
				end
				if (out_byte !== want.ch) begin
					$error("out_byte: expected %02h, got %02h", want.ch, out_byte);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0b, got %0b", want.last, out_last);
					errors++;
				end
			end
		end
	end

	initial begin : receiver
		int unsigned gap;
		res_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				res_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				gap = idle_len();
				if (gap != 0) begin
					res_ready = 1'b0;
					repeat (gap) @(negedge clk);
				end
				res_ready = 1'b1;
				@(negedge clk);
			end
		end
	end

	task automatic send_word(input logic [7:0] ch, input logic last = 1'b0);
		int unsigned gap;
		int          n0;
		gap = idle_len();
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_byte = ch;
		in_last = last;
		n0 = words_in;
		do @(negedge clk); while (words_in == n0);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (stripped_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic test_ascii_and_strays();
		send_word(8'h00);
		send_word(8'h7F);
		send_word(8'h80);
		send_word(8'hBF);
		send_word(8'hF8);
		send_word(8'hFF);
		send_word("z", 1'b1);
		drain();
	endtask

	task automatic test_c3_pairs();
		send_word(ulas_pkg::BYTE_LEAD_C3); send_word(8'h80);
		send_word(ulas_pkg::BYTE_LEAD_C3); send_word(8'hBF);
		send_word(ulas_pkg::BYTE_LEAD_C3); send_word(8'h86);
		send_word(ulas_pkg::BYTE_LEAD_C3); send_word(8'h41);
		send_word(ulas_pkg::BYTE_LEAD_C3); send_word(8'hFF, 1'b1);
		drain();
	endtask

	task automatic test_dropped_sequences();
		send_word(8'hC2); send_word(8'hA9);
		send_word(8'hDF); send_word(8'h00);
		send_word(8'hE2); send_word(8'h82); send_word(8'hAC);
		send_word(8'hF7); send_word(8'hFF); send_word(8'h00); send_word(8'h80);
		send_word(8'hE0); send_word(8'h82, 1'b1);
		send_word(ulas_pkg::BYTE_LEAD_C3, 1'b1);
		send_word(8'hC0, 1'b1);
		drain();
	endtask

	task automatic send_random_text(input int target);
		logic [7:0] seq[$];
		int         sent;
		int unsigned k;
		sent = 0;
		while (sent < target) begin
			seq.delete();
			k = $urandom_range(0, 99);
			if (k < 30) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else if (k < 55) begin
				seq.push_back(ulas_pkg::BYTE_LEAD_C3);
				seq.push_back({ulas_pkg::MARK_CONT, 6'($urandom)});
			end else if (k < 62) begin
				seq.push_back(ulas_pkg::BYTE_LEAD_C3);
				seq.push_back(8'($urandom));
			end else if (k < 70) begin
				seq.push_back({ulas_pkg::MARK_LEAD2, 5'($urandom)});
				seq.push_back(8'($urandom));
			end else if (k < 80) begin
				seq.push_back({ulas_pkg::MARK_LEAD3, 4'($urandom)});
				repeat (2) seq.push_back({ulas_pkg::MARK_CONT, 6'($urandom)});
			end else if (k < 88) begin
				seq.push_back({ulas_pkg::MARK_LEAD4, 3'($urandom)});
				repeat (3) seq.push_back(8'($urandom));
			end else if (k < 94) begin
				seq.push_back($urandom_range(0, 1) ? 8'($urandom_range(128, 191))
					: 8'($urandom_range(248, 255)));
			end else begin
				seq.push_back(8'($urandom));
			end
			foreach (seq[i]) send_word(seq[i], $urandom_range(0, 39) == 0);
			sent += seq.size();
		end
	endtask

	task automatic test_random();
		send_random_text(440);
		drain();
	endtask

	task automatic test_streaming();
		no_idle = 1'b1;
		send_random_text(40);
		drain();
		no_idle = 1'b0;
	endtask

	// long receiver stall while unknown pairs keep coming at full rate
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_req = 1'b1;
		repeat (20) begin
			send_word(ulas_pkg::BYTE_LEAD_C3);
			send_word(8'h86);
		end
		send_word("!", 1'b1);
		drain();
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		in_last = 1'b0;
		seq_pending = 1'b0;
		seq_c3 = 1'b0;
		seq_skip = 2'd0;
		words_in = 0;
		chars_checked = 0;
		texts_ended = 0;
		letters_mapped = 0;
		errors = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_ascii_and_strays();
		test_c3_pairs();
		test_dropped_sequences();
		test_random();
		test_streaming();
		test_backpressure();
		$display("covered %0d input words, %0d result words checked, %0d texts ended,",
			words_in, chars_checked, texts_ended);
		$display("%0d accented letters folded, with idling, streaming and a long stall",
			letters_mapped);
		if (errors == 0) begin
			$display("tb_utf8_latin_accent_stripper: done, clean");
		end else begin
			$display("tb_utf8_latin_accent_stripper: done, errors");
		end
		$finish;
	end

endmodule
